@@ hw/rtl/ilfc_pkg.sv @@
`default_nettype none
// ============================================================================
// ilfc_pkg - integer list format checker shared definitions
// Widths, character codes, token and phase types used by the front and back.
// ============================================================================
package ilfc_pkg;

    // Signed integer width being checked
    localparam int INT_BITS = 32;

    // Magnitude accumulator width and the widened product width for x10 + d
    localparam int MAG_W = INT_BITS + 1;
    localparam int MUL_W = MAG_W + 4;

    localparam logic [MAG_W-1:0] MAG_NEG_MAX = MAG_W'(1) << (INT_BITS - 1);
    localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_NEG_MAX - MAG_W'(1);
    localparam logic [MAG_W-1:0] MAG_CAP     = MAG_NEG_MAX + MAG_W'(1);

    // Token queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    typedef enum logic [2:0] {
        TK_DIGIT   = 3'd0,
        TK_PLUS    = 3'd1,
        TK_MINUS   = 3'd2,
        TK_COMMA   = 3'd3,
        TK_NEWLINE = 3'd4,
        TK_OTHER   = 3'd5,
        TK_END     = 3'd6
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic [3:0] digit;
    } t_token;

    typedef enum logic [4:0] {
        PH_START   = 5'b00001,
        PH_SIGN    = 5'b00010,
        PH_DIGITS  = 5'b00100,
        PH_NEWLINE = 5'b01000,
        PH_REJECT  = 5'b10000
    } t_phase;

endpackage : ilfc_pkg
`default_nettype wire

@@ hw/rtl/ilfc_front.sv @@
`default_nettype none
// ============================================================================
// ilfc_front - request classifier and token queue
// Turns each accepted request into a token and holds it in a short queue.
// ============================================================================
module ilfc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic            i_kind,
    input  wire logic [7:0]      i_text_byte,
    output logic                 o_tok_valid,
    output ilfc_pkg::t_token     o_tok,
    input  wire logic            i_tok_pop
);
    import ilfc_pkg::*;

    t_token              r_q [QDEPTH];
    logic [QPTR_W-1:0]   r_wptr, r_rptr;
    logic [QCNT_W-1:0]   r_count;
    t_token              w_tok;
    logic                w_push;
    logic                w_pop;

    // classify
    always_comb begin
        w_tok.digit = 4'd0;
        if (i_kind) begin
            w_tok.kind = TK_END;
        end else if (i_text_byte >= CH_ZERO && i_text_byte <= CH_NINE) begin
            w_tok.kind  = TK_DIGIT;
            w_tok.digit = 4'(i_text_byte - CH_ZERO);
        end else if (i_text_byte == CH_PLUS) begin
            w_tok.kind = TK_PLUS;
        end else if (i_text_byte == CH_MINUS) begin
            w_tok.kind = TK_MINUS;
        end else if (i_text_byte == CH_COMMA) begin
            w_tok.kind = TK_COMMA;
        end else if (i_text_byte == CH_NEWLINE) begin
            w_tok.kind = TK_NEWLINE;
        end else begin
            w_tok.kind = TK_OTHER;
        end
    end

    assign o_stall     = (r_count == QCNT_W'(QDEPTH));
    assign o_tok_valid = (r_count != '0);
    assign o_tok       = r_q[r_rptr];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_tok_pop && o_tok_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule : ilfc_front
`default_nettype wire

@@ hw/rtl/ilfc_back.sv @@
`default_nettype none
// ============================================================================
// ilfc_back - format state machine and result register
// Consumes tokens, tracks sign and saturating magnitude, answers on end.
// ============================================================================
module ilfc_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_tok_valid,
    input  wire ilfc_pkg::t_token i_tok,
    output logic                 o_tok_pop,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic                 o_accepted
);
    import ilfc_pkg::*;

    t_phase              r_phase, n_phase;
    logic                r_neg, n_neg;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic                r_out_valid;
    logic                r_out_acc;

    logic [MAG_W-1:0]    w_base;
    logic [MUL_W-1:0]    w_prod;
    logic [MAG_W-1:0]    w_mag_next;
    logic                w_in_range;
    logic                w_is_end;

    // x10 + d as shift-add, saturating at the cap
    assign w_base     = (r_phase == PH_START) ? '0 : r_mag;
    assign w_prod     = (MUL_W'(w_base) << 3) + (MUL_W'(w_base) << 1) + MUL_W'(i_tok.digit);
    assign w_mag_next = (w_prod > MUL_W'(MAG_CAP)) ? MAG_CAP : w_prod[MAG_W-1:0];
    assign w_in_range = r_neg ? (r_mag <= MAG_NEG_MAX) : (r_mag <= MAG_POS_MAX);

    assign w_is_end  = (i_tok.kind == TK_END);
    // end tokens wait for room in the result register
    assign o_tok_pop = i_tok_valid && (!w_is_end || !r_out_valid || !i_stall);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        if (o_tok_pop) begin
            if (w_is_end) begin
                n_phase = PH_START;
                n_neg   = 1'b0;
                n_mag   = '0;
            end else begin
                case (r_phase)
                    PH_START: begin
                        n_neg = (i_tok.kind == TK_MINUS);
                        n_mag = '0;
                        case (i_tok.kind)
                            TK_PLUS, TK_MINUS: n_phase = PH_SIGN;
                            TK_DIGIT: begin
                                n_mag   = w_mag_next;
                                n_phase = PH_DIGITS;
                            end
                            default: n_phase = PH_REJECT;
                        endcase
                    end
                    PH_SIGN: begin
                        if (i_tok.kind == TK_DIGIT) begin
                            n_mag   = w_mag_next;
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_REJECT;
                        end
                    end
                    PH_DIGITS: begin
                        if (i_tok.kind == TK_DIGIT) begin
                            n_mag = w_mag_next;
                        end else if (!w_in_range) begin
                            n_phase = PH_REJECT;
                        end else if (i_tok.kind == TK_COMMA) begin
                            n_phase = PH_START;
                            n_neg   = 1'b0;
                            n_mag   = '0;
                        end else if (i_tok.kind == TK_NEWLINE) begin
                            n_phase = PH_NEWLINE;
                        end else begin
                            n_phase = PH_REJECT;
                        end
                    end
                    default: n_phase = PH_REJECT;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            if (o_tok_pop && w_is_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop && w_is_end) begin
            r_out_acc <= (r_phase == PH_NEWLINE);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_accepted = r_out_acc;

    a_mag_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag <= MAG_CAP)
        else $error("magnitude above saturation cap");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START) |-> (r_mag == '0 && !r_neg))
        else $error("number start with stale accumulator");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && w_is_end) |=> (r_phase == PH_START && o_valid))
        else $error("end token did not reset and answer");

    a_accept_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && w_is_end && r_phase == PH_NEWLINE) |=> o_accepted)
        else $error("well-formed text not accepted");

endmodule : ilfc_back
`default_nettype wire

@@ hw/rtl/int_list_format_checker_top.sv @@
`default_nettype none
// ============================================================================
// int_list_format_checker_top - comma-separated signed integer list checker
// Streams text bytes and answers accept/reject on each end-of-input request.
// ============================================================================
// Each input request carries one text byte (i_kind = 0) or the end marker
// (i_kind = 1). The text passes when it is one or more signed decimal
// integers (optional + or -, at least one digit, within the signed
// INT_BITS-bit range) separated by commas, no spaces, ending in exactly one
// newline. Only the end marker yields a result request on o_valid /
// o_accepted, and it rearms the checker for the next text. Throughput is one
// request per cycle with no bubbles while o_stall is low: the front classifies
// the byte and pushes a token into a two-entry queue, and the back applies one
// token per cycle unless an end token waits (its x10 + digit shift-add with
// saturation is the combinational step that sets the rate). An end marker's
// result passes from the queue into an output register, so further bytes keep
// flowing while a result waits on i_stall; the queue fills and o_stall rises
// only when a second end marker arrives behind an untaken result.
// ============================================================================
module int_list_format_checker_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input request channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_text_byte,
    // result request channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_accepted
);
    import ilfc_pkg::*;

    logic   w_tok_valid;
    t_token w_tok;
    logic   w_tok_pop;

    // byte classification and token queue
    ilfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_text_byte (i_text_byte),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok),
        .i_tok_pop   (w_tok_pop)
    );

    // format state machine, accumulator and result register
    ilfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (w_tok_valid),
        .i_tok       (w_tok),
        .o_tok_pop   (w_tok_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_accepted  (o_accepted)
    );

endmodule : int_list_format_checker_top
`default_nettype wire

@@ dv/int_list_format_checker_top_tb.sv @@
// ============================================================================
// int_list_format_checker_top_tb - integer list format checker testbench
// Streams short texts (well-formed integer lists, damaged lists and byte
// noise) into the checker. A local model scores every accepted request, and
// the verdicts that come back are matched in order. Both channels idle at
// random, and one long result hold-off backs the block up.
// ============================================================================
module int_list_format_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ilfc_pkg::*;

    // Model widths, kept apart from the RTL accumulator constants
    localparam int VAL_BITS = ilfc_pkg::INT_BITS;
    localparam int ACC_W    = VAL_BITS + 1;
    localparam logic [ACC_W-1:0] NEG_LIMIT = ACC_W'(1) << (VAL_BITS - 1);
    localparam logic [ACC_W-1:0] POS_LIMIT = NEG_LIMIT - ACC_W'(1);
    localparam logic [ACC_W-1:0] SAT_LEVEL = NEG_LIMIT + ACC_W'(1);

    localparam int TEXT_ITEMS = 1450;   // stimulus stops once this many are queued
    localparam int HOLD_OFF   = 400;    // long result hold-off, in cycles
    localparam int DRAIN      = 20;     // quiet cycles after the last verdict

    typedef struct packed {
        logic       kind;   // 0 = text byte, 1 = end of input
        logic [7:0] ch;
    } t_text_req;

    // DUT hookup; every input starts at a known value
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       tx_valid    = 1'b0;
    logic       tx_kind     = 1'b0;
    logic [7:0] tx_byte     = 8'h00;
    logic       rx_stall    = 1'b0;
    logic       dut_stall;
    logic       dut_valid;
    logic       dut_accepted;

    int_list_format_checker_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (tx_valid),
        .o_stall     (dut_stall),
        .i_kind      (tx_kind),
        .i_text_byte (tx_byte),
        .o_valid     (dut_valid),
        .i_stall     (rx_stall),
        .o_accepted  (dut_accepted)
    );

    // Pending requests, expected verdicts, bookkeeping
    t_text_req  pending_reqs[$];
    logic       expected_verdicts[$];
    int         queued_items  = 0;
    int         verdicts_seen = 0;
    bit         failed        = 1'b0;
    logic       hold_off      = 1'b0;

    // Local copy of the checker state
    t_phase           chk_phase = PH_START;
    logic             chk_neg   = 1'b0;
    logic [ACC_W-1:0] chk_mag   = '0;

    // Clock: 12 ns period
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #12ms;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Checker model
    // ------------------------------------------------------------------------

    // magnitude x10 + digit, pinned at the saturation level
    function automatic logic [ACC_W-1:0] shift_in_digit(logic [ACC_W-1:0] m, logic [3:0] d);
        logic [ACC_W+3:0] wide;
        wide = {4'b0, m} * 4'd10 + d;
        return (wide > SAT_LEVEL) ? SAT_LEVEL : wide[ACC_W-1:0];
    endfunction

    // Advance the model by one accepted request; an end marker yields a verdict
    function automatic void score_request(logic kind, logic [7:0] ch);
        logic       is_digit;
        logic [3:0] digit;
        logic       fits;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        digit    = 4'(ch - CH_ZERO);
        fits     = chk_neg ? (chk_mag <= NEG_LIMIT) : (chk_mag <= POS_LIMIT);
        if (kind) begin
            // the end rearms the checker whatever came before
            expected_verdicts.push_back(chk_phase == PH_NEWLINE);
            chk_phase = PH_START;
            chk_neg   = 1'b0;
            chk_mag   = '0;
            return;
        end
        case (chk_phase)
            PH_START: begin
                chk_neg = 1'b0;
                chk_mag = '0;
                if (ch == CH_PLUS) begin
                    chk_phase = PH_SIGN;
                end else if (ch == CH_MINUS) begin
                    chk_neg   = 1'b1;
                    chk_phase = PH_SIGN;
                end else if (is_digit) begin
                    chk_mag   = shift_in_digit(chk_mag, digit);
                    chk_phase = PH_DIGITS;
                end else begin
                    chk_phase = PH_REJECT;
                end
            end
            PH_SIGN: begin
                if (is_digit) begin
                    chk_mag   = shift_in_digit(chk_mag, digit);
                    chk_phase = PH_DIGITS;
                end else begin
                    chk_phase = PH_REJECT;
                end
            end
            PH_DIGITS: begin
                // the range check happens on the delimiter, not per digit
                if (is_digit) begin
                    chk_mag = shift_in_digit(chk_mag, digit);
                end else if (!fits) begin
                    chk_phase = PH_REJECT;
                end else if (ch == CH_COMMA) begin
                    chk_neg   = 1'b0;
                    chk_mag   = '0;
                    chk_phase = PH_START;
                end else if (ch == CH_NEWLINE) begin
                    chk_phase = PH_NEWLINE;
                end else begin
                    chk_phase = PH_REJECT;
                end
            end
            default: begin
                // after the newline anything rejects; a rejected text stays so
                chk_phase = PH_REJECT;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long
    function automatic int next_gap(bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void queue_req(logic kind, logic [7:0] ch);
        t_text_req r;
        r.kind = kind;
        r.ch   = ch;
        pending_reqs.push_back(r);
        queued_items++;
    endfunction

    // Queue a text and its end marker; the end carries a junk byte
    function automatic void queue_text(logic [7:0] text[$]);
        foreach (text[i]) begin
            queue_req(1'b0, text[i]);
        end
        queue_req(1'b1, 8'($urandom_range(0, 255)));
    endfunction

    function automatic void queue_string(string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
        queue_text(text);
    endfunction

    // One signed number; weighted toward the range limits and overflow
    function automatic string number_text();
        string           s;
        longint unsigned v;
        int              pick;
        case ($urandom_range(0, 2))
            0: s = "";
            1: s = "+";
            default: s = "-";
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            v = $urandom_range(0, 999);
            s = $sformatf("%s%0d", s, v);
        end else if (pick < 60) begin
            v = $urandom;
            s = $sformatf("%s%0d", s, v);
        end else if (pick < 82) begin
            // straddle 2^(N-1)-1 / 2^(N-1) / 2^(N-1)+1
            v = (64'd1 << (VAL_BITS - 1)) - 64'd3 + 64'($urandom_range(0, 6));
            s = $sformatf("%s%0d", s, v);
        end else if (pick < 92) begin
            // long digit runs drive the accumulator into saturation
            for (int i = $urandom_range(10, 24); i > 0; i--) begin
                s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            end
        end else begin
            // leading zeros in front of a limit-sized value
            v = (64'd1 << (VAL_BITS - 1)) - 64'd1 + 64'($urandom_range(0, 1));
            s = $sformatf("%s000%0d", s, v);
        end
        return s;
    endfunction

    function automatic logic [7:0] odd_byte();
        case ($urandom_range(0, 5))
            0: return CH_COMMA;
            1: return CH_NEWLINE;
            2: return CH_PLUS;
            3: return CH_MINUS;
            4: return 8'h20;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed lists with random content, some damaged, some noise
    function automatic void queue_random_text();
        logic [7:0] text[$];
        string      s;
        int         pos;
        if ($urandom_range(0, 9) == 0) begin
            for (int i = $urandom_range(0, 8); i > 0; i--) begin
                text.push_back(8'($urandom_range(0, 255)));
            end
            queue_text(text);
            return;
        end
        s = number_text();
        for (int i = $urandom_range(0, 3); i > 0; i--) begin
            s = {s, ",", number_text()};
        end
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
        text.push_back(CH_NEWLINE);
        if ($urandom_range(0, 3) == 0) begin
            pos = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 4))
                0: text[pos] = odd_byte();
                1: text.insert(pos, odd_byte());
                2: text.delete(pos);
                3: void'(text.pop_back());          // no newline
                default: text.push_back(odd_byte()); // trailing byte
            endcase
        end
        queue_text(text);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers pending requests, scores each one as it is taken
    // ------------------------------------------------------------------------
    int tx_wait      = 0;
    int tx_mode_left = 0;
    bit tx_calm      = 1'b0;

    always @(posedge i_clk) begin
        t_text_req r;
        if (!i_rst_n) begin
            tx_valid <= 1'b0;
        end else begin
            if (tx_mode_left == 0) begin
                tx_calm      = ($urandom_range(0, 3) == 0);
                tx_mode_left = $urandom_range(20, 200);
            end else begin
                tx_mode_left--;
            end
            if (tx_valid && !dut_stall) begin
                score_request(tx_kind, tx_byte);
            end
            // a stalled request stays put; otherwise load the next or idle
            if (!tx_valid || !dut_stall) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    tx_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    r = pending_reqs.pop_front();
                    tx_valid <= 1'b1;
                    tx_kind  <= r.kind;
                    tx_byte  <= r.ch;
                    tx_wait  = next_gap(tx_calm);
                end else begin
                    tx_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each taken verdict, stalls the result channel at random
    // ------------------------------------------------------------------------
    int rx_wait      = 0;
    int rx_mode_left = 0;
    bit rx_calm      = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall <= 1'b0;
        end else begin
            if (dut_valid && !rx_stall) begin
                verdicts_seen++;
                if (expected_verdicts.size() == 0) begin
                    $error("verdict with none expected: accepted=%0b", dut_accepted);
                    failed = 1'b1;
                end else if (dut_accepted !== expected_verdicts[0]) begin
                    $error("accepted mismatch: expected %0b, actual %0b",
                           expected_verdicts[0], dut_accepted);
                    failed = 1'b1;
                    void'(expected_verdicts.pop_front());
                end else begin
                    void'(expected_verdicts.pop_front());
                end
            end
            if (rx_mode_left == 0) begin
                rx_calm      = ($urandom_range(0, 3) == 0);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            if (rx_wait > 0) begin
                rx_wait--;
            end else begin
                rx_wait = next_gap(rx_calm);
            end
            rx_stall <= hold_off || (rx_wait > 0);
        end
    end

    // Long hold-off: the sender keeps going, so end markers pile up behind
    // an untaken verdict and the input side has to stall
    initial begin
        while (verdicts_seen < 8) begin
            @(posedge i_clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_OFF) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of test
    // ------------------------------------------------------------------------
    initial begin
        // directed: empty text, lone sign, sign then comma, missing newline,
        // byte after the newline, out-of-set byte, minus zero in a list,
        // explicit plus
        queue_string("");
        queue_string("+");
        queue_string("-,");
        queue_string("7");
        queue_string("0\nA");
        queue_string("\377");
        queue_string("1,-0\n");
        queue_string("+9\n");
        while (queued_items < TEXT_ITEMS) begin
            queue_random_text();
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || tx_valid) begin
            @(posedge i_clk);
        end
        while (expected_verdicts.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);

        if (!failed) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule : int_list_format_checker_top_tb
